// ===== src/blur_pkg.sv =====
// Shared types, constants and codes of the weighted 3x3 blur.
package blur_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;

    localparam int COL_W  = 11;
    localparam int ROW_W  = 13;
    localparam int ADDR_W = $clog2(MAX_WIDTH);
    localparam int CFG_W  = 13;
    localparam int CHAN_W = 8;
    localparam int SUM_W  = 13;

    localparam logic [COL_W-1:0] WIDTH_RESET  = COL_W'(640);
    localparam logic [ROW_W-1:0] HEIGHT_RESET = ROW_W'(480);
    localparam logic [COL_W-1:0] WIDTH_MAX    = COL_W'(MAX_WIDTH);
    localparam logic [ROW_W-1:0] HEIGHT_MAX   = ROW_W'(MAX_HEIGHT);

    localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

    // floor(x / 19) = (x * 6899) >> 17 for all x up to 19 * 255
    localparam int              DIV_SHIFT = 17;
    localparam logic [SUM_W-1:0] DIV_MUL  = SUM_W'(6899);

    typedef enum logic {
        CMD_PIXEL = 1'b0,
        CMD_DRAIN = 1'b1
    } t_cmd;

    typedef enum logic [0:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } t_pixel;

    typedef struct packed {
        logic emit;
        logic first_col;
        logic last_col;
        logic first_row;
        logic last_row;
        logic last;
    } t_pos_info;

    typedef struct packed {
        logic   last;
        t_pixel pix;
    } t_result;

endpackage

// ===== src/blur_ctrl.sv =====
// Configuration registers and raster position counters of the blur.
module blur_ctrl
    import blur_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [0:0]          i_cfg_index,
    input  logic [CFG_W-1:0]    i_cfg_data,
    input  logic                i_accept,
    input  logic                i_cmd,
    input  t_pixel              i_pixel,
    output logic [ADDR_W-1:0]   o_addr,
    output t_pixel              o_pixel,
    output t_pos_info           o_info
);

    logic [COL_W-1:0] r_frame_width;
    logic [ROW_W-1:0] r_frame_height;
    logic [COL_W-1:0] r_in_col,  n_in_col;
    logic [ROW_W-1:0] r_in_row,  n_in_row;
    logic [COL_W-1:0] r_out_col, n_out_col;
    logic [ROW_W-1:0] r_out_row, n_out_row;

    logic [COL_W-1:0] w;
    logic [ROW_W-1:0] h;
    logic [COL_W-1:0] ic, oc, ic_inc, oc_inc;
    logic [ROW_W-1:0] ir, orow;
    logic             emit, last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= WIDTH_RESET;
            r_frame_height <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[COL_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[ROW_W-1:0];
            endcase
        end
    end

    always_comb begin
        w = r_frame_width;
        if (r_frame_width == '0) begin
            w = COL_W'(1);
        end else if (r_frame_width > WIDTH_MAX) begin
            w = WIDTH_MAX;
        end
        h = r_frame_height;
        if (r_frame_height == '0) begin
            h = ROW_W'(1);
        end else if (r_frame_height > HEIGHT_MAX) begin
            h = HEIGHT_MAX;
        end

        // wrap columns left past a shrunk width, restart past the height
        ic = r_in_col;
        ir = r_in_row;
        if (r_in_col >= w) begin
            ic = '0;
            ir = r_in_row + ROW_W'(1);
        end
        oc   = r_out_col;
        orow = r_out_row;
        if (r_out_col >= w) begin
            oc   = '0;
            orow = r_out_row + ROW_W'(1);
        end
        if (orow >= h) begin
            ic   = '0;
            ir   = '0;
            oc   = '0;
            orow = '0;
        end

        emit = (ir >= ROW_W'(2)) || ((ir == ROW_W'(1)) && (ic != '0));
        last = emit && (orow == h - ROW_W'(1)) && (oc == w - COL_W'(1));

        ic_inc    = ic + COL_W'(1);
        n_in_col  = ic_inc;
        n_in_row  = ir;
        if (ic_inc >= w) begin
            n_in_col = '0;
            n_in_row = ir + ROW_W'(1);
        end
        oc_inc    = oc + COL_W'(1);
        n_out_col = oc;
        n_out_row = orow;
        if (emit) begin
            n_out_col = oc_inc;
            if (oc_inc >= w) begin
                n_out_col = '0;
                n_out_row = orow + ROW_W'(1);
            end
        end
        if (last) begin
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_col = '0;
            n_out_row = '0;
        end

        o_addr           = ic[ADDR_W-1:0];
        o_pixel          = (t_cmd'(i_cmd) == CMD_DRAIN) ? t_pixel'('0) : i_pixel;
        o_info.emit      = emit;
        o_info.first_col = (oc == '0);
        o_info.last_col  = (oc == w - COL_W'(1));
        o_info.first_row = (orow == '0);
        o_info.last_row  = (orow == h - ROW_W'(1));
        o_info.last      = last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (i_accept) begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
        end
    end

endmodule

// ===== src/blur_line_store.sv =====
// Two row memories with read-modify-write and the 3x3 window registers.
module blur_line_store
    import blur_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  logic                i_accept,
    input  logic [ADDR_W-1:0]   i_addr,
    input  t_pixel              i_pixel,
    input  t_pos_info           i_info,
    output t_pixel              o_win [9],
    output logic                o_valid,
    output t_pos_info           o_info
);

    t_pixel mem_older [MAX_WIDTH];
    t_pixel mem_newer [MAX_WIDTH];

    logic              r_b_valid;
    logic [ADDR_W-1:0] r_b_addr;
    t_pixel            r_b_pixel;
    t_pos_info         r_b_info;
    t_pixel            r_rd_older;
    t_pixel            r_rd_newer;
    logic              r_fwd;
    t_pixel            r_fwd_older;
    t_pixel            r_fwd_newer;
    t_pixel            r_win [9];
    logic              r_c_valid;
    t_pos_info         r_c_info;

    t_pixel top, mid;
    logic   wr_en;

    assign top   = r_fwd ? r_fwd_older : r_rd_older;
    assign mid   = r_fwd ? r_fwd_newer : r_rd_newer;
    assign wr_en = i_adv && r_b_valid;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_older[r_b_addr] <= mid;
        end
        if (i_accept) begin
            r_rd_older <= mem_older[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_newer[r_b_addr] <= r_b_pixel;
        end
        if (i_accept) begin
            r_rd_newer <= mem_newer[i_addr];
        end
    end

    // forward the write that lands on the same entry as this read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (i_accept) begin
            r_fwd <= wr_en && (r_b_addr == i_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_fwd_older <= mid;
            r_fwd_newer <= r_b_pixel;
            r_b_addr    <= i_addr;
            r_b_pixel   <= i_pixel;
            r_b_info    <= i_info;
        end
        if (wr_en) begin
            r_c_info <= r_b_info;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= '0;
            end
        end else if (wr_en) begin
            for (int k = 0; k < 6; k++) begin
                r_win[k] <= r_win[k+3];
            end
            r_win[6] <= top;
            r_win[7] <= mid;
            r_win[8] <= r_b_pixel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else if (i_adv) begin
            r_b_valid <= i_accept;
            r_c_valid <= r_b_valid && r_b_info.emit;
        end
    end

    assign o_win   = r_win;
    assign o_valid = r_c_valid;
    assign o_info  = r_c_info;

endmodule

// ===== src/blur_kernel.sv =====
// Edge-clamped tap selection, weighted sum and division by nineteen.
module blur_kernel
    import blur_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_adv,
    input  logic       i_valid,
    input  t_pos_info  i_info,
    input  t_pixel     i_win [9],
    output logic       o_push,
    output t_result    o_result
);

    logic [SUM_W-1:0] r_d_sum [3];
    logic             r_d_valid;
    logic             r_d_last;

    t_pixel           tap [9];
    logic [SUM_W-1:0] n_sum [3];

    always_comb begin
        tap[0] = i_info.first_col ? i_win[3] : i_win[0];
        tap[1] = i_info.first_col ? i_win[4] : i_win[1];
        tap[2] = i_info.first_col ? i_win[5] : i_win[2];
        tap[3] = i_win[3];
        tap[4] = i_win[4];
        tap[5] = i_win[5];
        tap[6] = i_info.last_col ? i_win[3] : i_win[6];
        tap[7] = i_info.last_col ? i_win[4] : i_win[7];
        tap[8] = i_info.last_col ? i_win[5] : i_win[8];
        for (int c = 0; c < 3; c++) begin
            if (i_info.first_row) begin
                tap[3*c] = tap[3*c+1];
            end
            if (i_info.last_row) begin
                tap[3*c+2] = tap[3*c+1];
            end
        end
    end

    always_comb begin
        logic [SUM_W-1:0] ring;
        logic [SUM_W-1:0] centre;
        for (int k = 0; k < 3; k++) begin
            ring = '0;
            for (int t = 0; t < 9; t++) begin
                if (t != 4) begin
                    ring = ring + SUM_W'(tap[t][CHAN_W*k +: CHAN_W]);
                end
            end
            centre   = SUM_W'(tap[4][CHAN_W*k +: CHAN_W]);
            n_sum[k] = (ring << 1) + (centre << 1) + centre;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && i_valid) begin
            for (int k = 0; k < 3; k++) begin
                r_d_sum[k] <= n_sum[k];
            end
            r_d_last <= i_info.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (i_adv) begin
            r_d_valid <= i_valid;
        end
    end

    always_comb begin
        logic [2*SUM_W-1:0] prod;
        logic [3*CHAN_W-1:0] quo;
        quo = '0;
        for (int k = 0; k < 3; k++) begin
            prod = r_d_sum[k] * DIV_MUL;
            quo[CHAN_W*k +: CHAN_W] = prod[DIV_SHIFT +: CHAN_W];
        end
        o_result.pix  = t_pixel'(quo);
        o_result.last = r_d_last;
        o_push        = i_adv && r_d_valid;
    end

endmodule

// ===== src/blur_out_fifo.sv =====
// Two-entry output buffer that parts the pipeline from the downstream ready.
module blur_out_fifo
    import blur_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_result  i_result,
    input  logic     i_ready,
    output logic     o_valid,
    output t_result  o_result,
    output logic     o_full
);

    t_result    r_entry [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       pop;

    assign o_valid  = (r_count != 2'd0);
    assign o_full   = (r_count == 2'd2);
    assign o_result = r_entry[r_rd_ptr];
    assign pop      = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(pop);
        end
    end

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || pop))
        else $error("result pushed into full output buffer");

    a_valid_after_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |=> o_valid)
        else $error("pushed result not presented");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid)
        else $error("stalled result dropped");

endmodule

// ===== src/weighted_blur_3x3_clamped.sv =====
// Streaming 3x3 weighted blur with clamp-to-edge, top level.
// Each result passes the stage B, window and sum registers into the output buffer.
// One transfer per cycle while the output buffer is not full; each transfer does one
// read-modify-write of both row memories; the last row needs frame_width + 1 drain inputs.
// Reset (synchronous, active low) clears counters, window, pipeline and output buffer
// and sets the frame to 640 x 480; the row memories are not cleared.
module weighted_blur_3x3_clamped
    import blur_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [0:0]         i_cfg_index,
    input  logic [CFG_W-1:0]   i_cfg_data,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [23:0]        s_axis_tdata,   // red_in, green_in, blue_in
    input  logic               s_axis_tuser,   // command
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [31:0]        m_axis_tdata,   // red_out, green_out, blue_out, alpha_out
    output logic               m_axis_tlast
);

    logic              adv;
    logic              accept;
    logic [ADDR_W-1:0] rd_addr;
    t_pixel            in_pixel;
    t_pos_info         pos_info;
    t_pixel            win [9];
    logic              win_valid;
    t_pos_info         win_info;
    logic              push;
    t_result           kern_result;
    t_result           out_result;
    logic              fifo_full;

    assign adv           = !fifo_full;
    assign accept        = s_axis_tvalid && adv;
    assign s_axis_tready = adv;

    blur_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_cmd       (s_axis_tuser),
        .i_pixel     (t_pixel'(s_axis_tdata)),
        .o_addr      (rd_addr),
        .o_pixel     (in_pixel),
        .o_info      (pos_info)
    );

    blur_line_store u_line_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_accept (accept),
        .i_addr   (rd_addr),
        .i_pixel  (in_pixel),
        .i_info   (pos_info),
        .o_win    (win),
        .o_valid  (win_valid),
        .o_info   (win_info)
    );

    blur_kernel u_kernel (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_valid  (win_valid),
        .i_info   (win_info),
        .i_win    (win),
        .o_push   (push),
        .o_result (kern_result)
    );

    blur_out_fifo u_out_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_result (kern_result),
        .i_ready  (m_axis_tready),
        .o_valid  (m_axis_tvalid),
        .o_result (out_result),
        .o_full   (fifo_full)
    );

    assign m_axis_tdata = {ALPHA_OPAQUE, 24'(out_result.pix)};
    assign m_axis_tlast = out_result.last;

endmodule
